// ----- sv/pbvd_pkg.sv -----
// shared types and constants for the palette block video decoder
`default_nettype none
package pbvd_pkg;
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW = 8;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_PAL   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [3:0] CODE_2 = 4'h2;
  localparam logic [3:0] CODE_3 = 4'h3;
  localparam logic [3:0] CODE_4 = 4'h4;
  localparam logic [3:0] CODE_5 = 4'h5;
  localparam logic [3:0] CODE_7 = 4'h7;
  localparam logic [3:0] CODE_8 = 4'h8;
  localparam logic [3:0] CODE_B = 4'hB;
  localparam logic [3:0] CODE_C = 4'hC;
  localparam logic [3:0] CODE_D = 4'hD;
  localparam logic [3:0] CODE_E = 4'hE;
  localparam logic [3:0] CODE_F = 4'hF;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] block_code;
    logic [6:0] block_col;
    logic [6:0] block_row;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } in_word_t;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_item;
    logic       block_done;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_GEN  = 2'd1,
    ST_OUT  = 2'd2
  } state_t;

  // one pixel request from the sequencer to the lookup stage
  typedef struct packed {
    logic       valid;
    logic [2:0] dx;
    logic [2:0] dy;
    logic [7:0] idx;
    logic       last;
    logic       done;
  } pix_req_t;

  function automatic logic [6:0] payload_len(input logic [3:0] code, input logic split);
    logic [6:0] n;
    case (code)
      CODE_2, CODE_3, CODE_4, CODE_E: n = 7'd1;
      CODE_5, CODE_F: n = 7'd2;
      CODE_7: n = split ? 7'd4 : 7'd10;
      CODE_8: n = split ? 7'd12 : 7'd16;
      CODE_B: n = 7'd64;
      CODE_C: n = 7'd16;
      CODE_D: n = 7'd4;
      default: n = 7'd0;
    endcase
    return n;
  endfunction
endpackage
`default_nettype wire

// ----- sv/pbvd_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module pbvd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/pbvd_seq.sv -----
// pixel sequencer: walks the pixels one byte determines, one per cycle unless held
`default_nettype none
module pbvd_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [3:0]        code,
  input  wire logic [6:0]        pos,
  input  wire logic [7:0]        b,
  input  wire logic [7:0]        c0,
  input  wire logic [7:0]        c1,
  input  wire logic              split,
  input  wire logic              fin,
  input  wire logic              hold,
  output pbvd_pkg::pix_req_t     req,
  output logic                   busy
);
  logic [5:0] cnt, cnt_next;
  logic [6:0] total, total_next;
  logic       run, run_next;
  logic [2:0] dx, dy;
  logic [7:0] idx;
  logic [1:0] nib_sel;
  logic [3:0] nib;

  // pixels produced by this byte
  always_comb begin
    total_next = 7'd0;
    case (code)
      pbvd_pkg::CODE_7: if (pos >= 7'd2) total_next = split ? 7'd32 : 7'd8;
      pbvd_pkg::CODE_8:
        if (pos != 7'd1 && !split && pos[1]) total_next = 7'd8;
      pbvd_pkg::CODE_B: total_next = 7'd1;
      pbvd_pkg::CODE_C: total_next = 7'd4;
      pbvd_pkg::CODE_D: total_next = 7'd16;
      pbvd_pkg::CODE_E: total_next = 7'd64;
      pbvd_pkg::CODE_F: if (pos != 7'd0) total_next = 7'd64;
      default: total_next = 7'd0;
    endcase
  end

  logic [7:0] bl;
  logic [5:0] cpos;
  logic [7:0] cc0, cc1, cb;
  logic [3:0] ccode;
  logic       csplit, cfin;
  always_ff @(posedge clk) begin
    if (start) begin
      cpos <= pos[5:0]; cb <= b; cc0 <= c0; cc1 <= c1;
      ccode <= code; csplit <= split; cfin <= fin;
    end
  end
  assign bl = cb;

  always_comb begin
    run_next = run;
    cnt_next = cnt;
    if (start) begin
      run_next = total_next != 7'd0;
      cnt_next = 6'd0;
    end else if (run && !hold) begin
      if ({1'b0, cnt} == total - 7'd1) run_next = 1'b0;
      else cnt_next = cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0; cnt <= 6'd0; total <= 7'd0;
    end else begin
      run <= run_next; cnt <= cnt_next;
      if (start) total <= total_next;
    end
  end

  // map the counter to an offset and a colour index
  always_comb begin
    dx = 3'd0; dy = 3'd0; idx = bl;
    nib_sel = 2'd0; nib = 4'd0;
    case (ccode)
      pbvd_pkg::CODE_7:
        if (!csplit) begin
          dx = cnt[2:0]; dy = 3'(cpos - 6'd2);
          idx = bl[3'd7 - cnt[2:0]] ? cc1 : cc0;
        end else begin
          dx = cnt[2:0];
          dy = {cpos[0], cnt[4:3]};
          nib = cnt[4] ? bl[3:0] : bl[7:4];
          nib_sel = 2'd3 - {1'b0, cnt[2]} * 2'd2 - {1'b0, cnt[1]};
          idx = nib[nib_sel] ? cc0 : cc1;
        end
      pbvd_pkg::CODE_8: begin
        dx = {cpos[2], cnt[1:0]};
        dy = {cpos[3], cpos[0], cnt[2]};
        idx = bl[3'd7 - cnt[2:0]] ? cc1 : cc0;
      end
      pbvd_pkg::CODE_B: begin
        dx = cpos[2:0]; dy = cpos[5:3];
      end
      pbvd_pkg::CODE_C: begin
        dx = {cpos[1:0], cnt[0]}; dy = {cpos[3:2], cnt[1]};
      end
      pbvd_pkg::CODE_D: begin
        dx = {cpos[0], cnt[1:0]}; dy = {cpos[1], cnt[3:2]};
      end
      pbvd_pkg::CODE_E: begin
        dx = cnt[2:0]; dy = cnt[5:3];
      end
      pbvd_pkg::CODE_F: begin
        dx = cnt[2:0]; dy = cnt[5:3];
        idx = (cnt[0] ^ cnt[3]) ? cc1 : cc0;
      end
      default: idx = bl;
    endcase
  end

  logic is_last;
  assign is_last = {1'b0, cnt} == total - 7'd1;
  assign req = '{valid: run, dx: dx, dy: dy, idx: idx, last: is_last,
                 done: is_last & cfin};
  assign busy = run;
endmodule
`default_nettype wire

// ----- sv/palette_block_video_decoder_unit.sv -----
// top level of the palette block video decoder
//  channel | dir | payload       | handshake
//  in      | in  | in_word_t     | in_valid / in_stall
//  out     | out | out_word_t    | out_valid / out_stall
// a start or palette word leaves the decoder idle; a payload byte holds off input
// while the pixel sequencer walks the pixels it draws (up to 64), one pixel per
// cycle unless out_stall holds it, through the single palette read port.
// reset clears control state; palette contents stay undefined until written.
// out_stall freezes the sequencer and the palette read; input stalls meanwhile.
`default_nettype none
module palette_block_video_decoder_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pbvd_pkg::in_word_t   in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pbvd_pkg::out_word_t       out_word
);
  pbvd_pkg::state_t state, state_next;
  logic [3:0] cur_code;
  logic [6:0] taken;
  logic       active, split;
  logic [7:0] c0, c1;
  logic [6:0] ocol, orow;
  logic       acc, is_byte, is_start, is_pal;
  logic       busy, hold, start_seq;
  logic [7:0] n_c0, n_c1;
  logic       n_split;
  logic [6:0] n_taken;
  logic       fin;
  pbvd_pkg::pix_req_t req;
  logic [23:0] rdata;
  logic        rd_valid;
  logic [2:0]  rd_dx, rd_dy;
  logic        rd_last, rd_done;

  assign acc      = in_valid && !in_stall;
  assign is_start = acc && in_word.kind == pbvd_pkg::KIND_START;
  assign is_byte  = acc && in_word.kind == pbvd_pkg::KIND_BYTE && active;
  assign is_pal   = acc && in_word.kind == pbvd_pkg::KIND_PAL;

  // colour bookkeeping for the byte just accepted
  always_comb begin
    n_c0 = c0; n_c1 = c1; n_split = split;
    case (cur_code)
      pbvd_pkg::CODE_7:
        if (taken == 7'd0) n_c0 = in_word.data_byte;
        else if (taken == 7'd1) begin
          n_c1 = in_word.data_byte; n_split = c0 > in_word.data_byte;
        end
      pbvd_pkg::CODE_8:
        if (taken == 7'd0) n_c0 = in_word.data_byte;
        else if (taken == 7'd1) begin
          n_c1 = in_word.data_byte; n_split = c0 > in_word.data_byte;
        end else if (!split && taken[1:0] == 2'd0) n_c0 = in_word.data_byte;
        else if (!split && taken[1:0] == 2'd1) n_c1 = in_word.data_byte;
      pbvd_pkg::CODE_F:
        if (taken == 7'd0) n_c0 = in_word.data_byte;
        else n_c1 = in_word.data_byte;
      default: n_c0 = c0;
    endcase
    n_taken = taken + 7'd1;
    fin = n_taken >= pbvd_pkg::payload_len(cur_code, n_split);
  end

  assign start_seq = is_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_code <= '0; taken <= '0; active <= 1'b0; split <= 1'b0;
      c0 <= '0; c1 <= '0; ocol <= '0; orow <= '0;
    end else if (is_start) begin
      cur_code <= in_word.block_code; taken <= '0; split <= 1'b0;
      c0 <= '0; c1 <= '0;
      ocol <= in_word.block_col; orow <= in_word.block_row;
      active <= pbvd_pkg::payload_len(in_word.block_code, 1'b0) != 7'd0;
    end else if (is_byte) begin
      c0 <= n_c0; c1 <= n_c1; split <= n_split; taken <= n_taken;
      if (fin) active <= 1'b0;
    end
  end

  pbvd_seq u_seq (
    .clk(clk), .rst(rst), .start(start_seq), .code(cur_code), .pos(taken),
    .b(in_word.data_byte), .c0(n_c0), .c1(n_c1), .split(n_split), .fin(fin),
    .hold(hold), .req(req), .busy(busy)
  );

  // output stage holds when stalled; read and request advance together
  assign hold = out_valid && out_stall;

  pbvd_ram #(.WIDTH(24), .DEPTH(pbvd_pkg::PALETTE_DEPTH)) u_pal (
    .clk(clk), .we(is_pal), .waddr(in_word.entry_index),
    .wdata({in_word.entry_red, in_word.entry_green, in_word.entry_blue}),
    .re(!hold), .raddr(req.idx), .rdata(rdata)
  );

  // the ram read register is the output register; its read is held while stalled
  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else if (!hold) rd_valid <= req.valid;
  end
  always_ff @(posedge clk) begin
    if (!hold) begin
      rd_dx <= req.dx; rd_dy <= req.dy; rd_last <= req.last; rd_done <= req.done;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pbvd_pkg::ST_IDLE: if (start_seq) state_next = pbvd_pkg::ST_GEN;
      pbvd_pkg::ST_GEN:  if (!busy) state_next = pbvd_pkg::ST_OUT;
      pbvd_pkg::ST_OUT:  if (!rd_valid || !out_stall) state_next = pbvd_pkg::ST_IDLE;
      default: state_next = pbvd_pkg::ST_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) state <= pbvd_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    in_stall = 1'b1;
    case (state)
      pbvd_pkg::ST_IDLE: in_stall = busy || (rd_valid && out_stall);
      default: in_stall = 1'b1;
    endcase
  end

  assign out_valid = rd_valid;
  assign out_word = '{
    pixel_x: {ocol, 3'd0} + {7'd0, rd_dx},
    pixel_y: {orow, 3'd0} + {7'd0, rd_dy},
    red: rdata[23:16], green: rdata[15:8], blue: rdata[7:0],
    last_of_item: rd_last, block_done: rd_done};
endmodule
`default_nettype wire

// ----- sv/pbvd_checker.sv -----
// port-level checks for the palette block video decoder
`default_nettype none
module pbvd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire pbvd_pkg::out_word_t out_word
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.last_of_item |-> in_stall)
    else $error("input taken mid item");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.block_done |-> out_word.last_of_item)
    else $error("block_done without last_of_item");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");
endmodule

bind palette_block_video_decoder_unit pbvd_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
`default_nettype wire

// ----- bench/palette_block_video_decoder_unit_tb.sv -----
// self-checking testbench for the palette block video decoder, with its own pixel predictor
`default_nettype none
module palette_block_video_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pbvd_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pbvd_pkg::out_word_t out_word;

  palette_block_video_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [23:0] pal_mem [pbvd_pkg::PALETTE_DEPTH];
  logic [3:0]  cur_code = '0;
  logic [6:0]  taken = '0;
  bit          blk_on = 1'b0;
  logic [7:0]  col0 = '0, col1 = '0;
  logic [6:0]  org_col = '0, org_row = '0;
  bit          split = 1'b0;

  pbvd_pkg::out_word_t pixel_q [$];
  pbvd_pkg::out_word_t scratch [$];
  int errors = 0;
  int pixels_seen = 0;
  int words_sent = 0;
  int blocks_sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  function automatic int blk_len(logic [3:0] code, bit sp);
    case (code)
      pbvd_pkg::CODE_2, pbvd_pkg::CODE_3, pbvd_pkg::CODE_4, pbvd_pkg::CODE_E: return 1;
      pbvd_pkg::CODE_5, pbvd_pkg::CODE_F: return 2;
      pbvd_pkg::CODE_7: return sp ? 4 : 10;
      pbvd_pkg::CODE_8: return sp ? 12 : 16;
      pbvd_pkg::CODE_B: return 64;
      pbvd_pkg::CODE_C: return 16;
      pbvd_pkg::CODE_D: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic void put_pixel(int dx, int dy, logic [7:0] idx);
    pbvd_pkg::out_word_t p;
    logic [9:0] ox, oy;
    ox = {3'b0, org_col} * 10'd8;
    oy = {3'b0, org_row} * 10'd8;
    p = '0;
    p.pixel_x = ox + 10'(dx);
    p.pixel_y = oy + 10'(dy);
    {p.red, p.green, p.blue} = pal_mem[idx];
    scratch.push_back(p);
  endfunction

  function automatic void draw_byte(logic [7:0] b, int pos);
    int g, r, qx, qy, k;
    logic [3:0] nib;
    case (cur_code)
      pbvd_pkg::CODE_7: begin
        if (pos == 0) col0 = b;
        else if (pos == 1) begin
          col1 = b;
          split = col0 > col1;
        end else if (!split) begin
          for (int x = 0; x < 8; x++) put_pixel(x, pos - 2, b[7 - x] ? col1 : col0);
        end else begin
          k = (pos - 2) & 1;
          for (int y = 0; y < 4; y++) begin
            nib = (y < 2) ? b[7:4] : b[3:0];
            for (int x = 0; x < 8; x++)
              put_pixel(x, 4 * k + y, nib[3 - (x >> 1)] ? col0 : col1);
          end
        end
      end
      pbvd_pkg::CODE_8: begin
        g = (pos >> 2) & 3;
        r = pos & 3;
        if (pos == 1) begin
          col1 = b;
          split = col0 > col1;
        end else if (split) begin
          // unfinished branch swallows the bytes
        end else if (r == 0) col0 = b;
        else if (r == 1) col1 = b;
        else begin
          qx = (g & 1) * 4;
          qy = (g >> 1) * 4 + (r - 2) * 2;
          for (int y = 0; y < 2; y++)
            for (int x = 0; x < 4; x++)
              put_pixel(qx + x, qy + y, b[7 - (y * 4 + x)] ? col1 : col0);
        end
        if (pos == 0) col0 = b;
      end
      pbvd_pkg::CODE_B: put_pixel(pos & 7, (pos >> 3) & 7, b);
      pbvd_pkg::CODE_C: begin
        for (int y = 0; y < 2; y++)
          for (int x = 0; x < 2; x++)
            put_pixel((pos & 3) * 2 + x, ((pos >> 2) & 3) * 2 + y, b);
      end
      pbvd_pkg::CODE_D: begin
        for (int y = 0; y < 4; y++)
          for (int x = 0; x < 4; x++)
            put_pixel((pos & 1) * 4 + x, ((pos >> 1) & 1) * 4 + y, b);
      end
      pbvd_pkg::CODE_E: begin
        for (int y = 0; y < 8; y++)
          for (int x = 0; x < 8; x++) put_pixel(x, y, b);
      end
      pbvd_pkg::CODE_F: begin
        if (pos == 0) col0 = b;
        else begin
          col1 = b;
          for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++) put_pixel(x, y, ((x + y) & 1) ? col1 : col0);
        end
      end
      default: ;
    endcase
  endfunction

  // predicts the pixels one accepted word causes, left in scratch
  function automatic void predict_word(pbvd_pkg::in_word_t w);
    bit fin;
    fin = 1'b0;
    scratch.delete();
    case (pbvd_pkg::kind_t'(w.kind))
      pbvd_pkg::KIND_START: begin
        cur_code = w.block_code;
        org_col = w.block_col;
        org_row = w.block_row;
        taken = '0;
        col0 = '0;
        col1 = '0;
        split = 1'b0;
        blk_on = blk_len(cur_code, 1'b0) > 0;
      end
      pbvd_pkg::KIND_BYTE: begin
        if (blk_on) begin
          draw_byte(w.data_byte, int'(taken));
          taken = taken + 7'd1;
          if (int'(taken) >= blk_len(cur_code, split)) begin
            blk_on = 1'b0;
            fin = 1'b1;
          end
        end
      end
      pbvd_pkg::KIND_PAL: pal_mem[w.entry_index] = {w.entry_red, w.entry_green, w.entry_blue};
      default: ;
    endcase
    if (scratch.size() > 0) begin
      scratch[scratch.size() - 1].last_of_item = 1'b1;
      scratch[scratch.size() - 1].block_done = fin;
    end
  endfunction

  function automatic pbvd_pkg::in_word_t mk(pbvd_pkg::kind_t k, logic [3:0] code,
                                            logic [6:0] col, logic [6:0] row,
                                            logic [7:0] d, logic [7:0] idx,
                                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pbvd_pkg::in_word_t w;
    w = '{k, code, col, row, d, idx, r, g, b};
    return w;
  endfunction

  // offer one word, with random gaps, and predict it once accepted
  task automatic send_word(pbvd_pkg::in_word_t w, bit has_exp = 1'b0,
                           pbvd_pkg::out_word_t exp = '0);
    while (!quiet && $urandom_range(99) < 21) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    if (has_exp) begin
      pixel_q.push_back(exp);
    end else begin
      foreach (scratch[i]) pixel_q.push_back(scratch[i]);
    end
    words_sent++;
  endtask

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel word, expected none, actual %p", $realtime, out_word);
        errors++;
      end else begin
        if (out_word !== pixel_q[0]) begin
          $display("%0t: pixel mismatch, expected %p, actual %p",
                   $realtime, pixel_q[0], out_word);
          errors++;
        end
        void'(pixel_q.pop_front());
      end
    end
  end

  typedef struct {
    pbvd_pkg::in_word_t  w;
    bit                  has_exp;
    pbvd_pkg::out_word_t exp;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    int code, n, cut;
    bit sp;
    logic [7:0] b0, b1;
    int rand_items;

    dir_rows.push_back('{mk(pbvd_pkg::KIND_PAL, 0, 0, 0, 0, 8'd0, 8'h00, 8'h00, 8'h00),
                         0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_PAL, 0, 0, 0, 0, 8'd255, 8'hff, 8'hff, 8'hff),
                         0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_PAL, 0, 0, 0, 0, 8'd1, 8'h12, 8'h34, 8'h56),
                         0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_PAL, 0, 0, 0, 0, 8'd128, 8'ha5, 8'h5a, 8'hc3),
                         0, '0});
    // byte while idle and the unused kind are both dropped
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd255, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_NONE, pbvd_pkg::CODE_E, 7'd5, 7'd5, 8'd1, 8'd1,
                            1, 1, 1), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_START, pbvd_pkg::CODE_B, 7'd127, 7'd127,
                            0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd255, 0, 0, 0, 0), 1,
                         '{10'd1016, 10'd1016, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0}});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd0, 0, 0, 0, 0), 1,
                         '{10'd1017, 10'd1016, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_START, pbvd_pkg::CODE_E, 7'd0, 7'd0,
                            0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd128, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_START, pbvd_pkg::CODE_F, 7'd5, 7'd9,
                            0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd1, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd255, 0, 0, 0, 0), 0, '0});
    // two-colour bitmap in quad form: first colour above the second
    dir_rows.push_back('{mk(pbvd_pkg::KIND_START, pbvd_pkg::CODE_7, 7'd1, 7'd2,
                            0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd255, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'ha5, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'h3c, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_START, 4'h0, 7'd3, 7'd3, 0, 0, 0, 0, 0), 0, '0});
    // tile block abandoned by a new start
    dir_rows.push_back('{mk(pbvd_pkg::KIND_START, pbvd_pkg::CODE_D, 7'd64, 7'd1,
                            0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd1, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_START, pbvd_pkg::CODE_2, 7'd2, 7'd2,
                            0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'd128, 0, 0, 0, 0), 0, '0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].exp);

    // fill the low palette entries that random payload bytes draw from
    for (int i = 0; i < 32; i++)
      send_word(mk(pbvd_pkg::KIND_PAL, 0, 0, 0, 0, 8'(i), 8'($urandom), 8'($urandom),
                   8'($urandom)));

    rand_items = 0;
    while (rand_items < 290) begin
      if (rand_items >= 60) hold_req = 1'b1;
      quiet = (rand_items >= 140 && rand_items < 220);
      case ($urandom_range(19))
        0: begin
          send_word(mk(pbvd_pkg::KIND_NONE, 4'($urandom), 7'($urandom), 7'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom)));
          rand_items++;
        end
        1: begin
          send_word(mk(pbvd_pkg::KIND_BYTE, 0, 0, 0, 8'($urandom_range(31)), 0, 0, 0, 0));
          rand_items++;
        end
        2: begin
          send_word(mk(pbvd_pkg::KIND_PAL, 0, 0, 0, 0, 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom)));
          rand_items++;
        end
        default: begin
          code = $urandom_range(15);
          b0 = 8'($urandom_range(31));
          b1 = 8'($urandom_range(31));
          sp = b0 > b1;
          n = blk_len(4'(code), sp);
          // some blocks are cut short; later random bytes may still feed them before a start abandons them
          cut = ($urandom_range(9) == 0 && n > 1) ? $urandom_range(n - 1) : n;
          send_word(mk(pbvd_pkg::KIND_START, 4'(code), 7'($urandom), 7'($urandom),
                       8'($urandom), 0, 0, 0, 0));
          blocks_sent++;
          rand_items++;
          for (int p = 0; p < cut; p++) begin
            send_word(mk(pbvd_pkg::KIND_BYTE, 0, 0, 0,
                         (p == 0) ? b0 : (p == 1) ? b1 : 8'($urandom_range(31)),
                         0, 0, 0, 0));
            rand_items++;
          end
        end
      endcase
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (pixel_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("run covered %0d accepted words, %0d random blocks, %0d pixel words checked",
             words_sent, blocks_sent, pixels_seen);
    if (errors == 0) begin
      $display("PASS palette_block_video_decoder_unit");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL palette_block_video_decoder_unit");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d pixel words still expected", pixel_q.size());
    $display("FAIL palette_block_video_decoder_unit");
    $finish;
  end
endmodule
`default_nettype wire
